[design/skf_pkg.sv]
// Shared package of the scalar Kalman filter: fixed-point formats, register codes,
// sequencer states and the request structs used between the sequencer and its units.
// No dependencies.
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = DATA_W + 1;       // unsigned Q1.32
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] RESET_PROCESS_NOISE = DATA_W'(2684);
    localparam logic [DATA_W-1:0] RESET_MEASURE_NOISE = DATA_W'(2684355);
    localparam logic [DATA_W-1:0] ONE_Q4_28           = DATA_W'(268435456);

    localparam logic [GAIN_W-1:0] ONE_Q32  = {1'b1, {DATA_W{1'b0}}};
    localparam logic [PROD_W-1:0] HALF_Q32 = PROD_W'(64'h0000_0000_8000_0000);

    // Divider: one quotient bit per step, bit 32 down to bit 0.
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Multiplier: one 8-bit digit of the second operand per step.
    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_STEPS   = DATA_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL1,
        S_MUL1_WAIT,
        S_MUL2,
        S_MUL2_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [GAIN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_mul_req;

endpackage

[design/skf_div.sv]
// Iterative restoring divider: floor((num << 32) / den), one quotient bit per cycle.
// Depends on skf_pkg.
module skf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skf_pkg::t_div_req             i_req,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [skf_pkg::GAIN_W-1:0]    o_quo
);
    import skf_pkg::*;

    logic [GAIN_W:0]        r_rem;
    logic [GAIN_W-1:0]      r_den;
    logic [GAIN_W-1:0]      r_quo;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_busy;
    logic                   r_first;
    logic                   r_zero;
    logic                   r_done;

    logic [GAIN_W:0]        w_trial;
    logic                   w_bit;

    // The first step compares the numerator itself, later steps the shifted remainder.
    assign w_trial = r_first ? r_rem : {r_rem[GAIN_W-1:0], 1'b0};
    assign w_bit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= {2'b00, i_req.num};
            r_den   <= i_req.den;
            r_quo   <= '0;
            r_first <= 1'b1;
            r_zero  <= (i_req.den == '0);
        end else if (r_busy) begin
            r_rem   <= w_bit ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quo   <= {r_quo[GAIN_W-2:0], w_bit};
            r_first <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 : r_quo;

endmodule

[design/skf_mul.sv]
// Iterative 32x32 multiplier: one 32x8 partial product is accumulated per cycle.
// Depends on skf_pkg.
module skf_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skf_pkg::t_mul_req             i_req,
    output logic                          o_done,
    output logic [skf_pkg::PROD_W-1:0]    o_prod
);
    import skf_pkg::*;

    logic [DATA_W-1:0]              r_a;
    logic [DATA_W-1:0]              r_b;
    logic [PROD_W-1:0]              r_acc;
    logic [MUL_CNT_W-1:0]           r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [DATA_W+MUL_DIGIT_W-1:0]  w_pp;

    // Digits are taken from the top of the second operand, so the sum shifts left.
    assign w_pp = r_a * r_b[DATA_W-1 -: MUL_DIGIT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == MUL_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[PROD_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                     + PROD_W'(w_pp);
            r_b   <= {r_b[DATA_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[design/scalar_kalman_filter_top.sv]
// Top level of the scalar Kalman filter: sequencer, state, configuration and output.
// Depends on skf_pkg, skf_div and skf_mul.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_stall     i_sample_value (signed Q16.16)
//   output    out        o_out_valid / i_out_stall   o_filtered_value, o_error_level
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Each sample request runs through the sequencer states in order: a start state ahead
// of each unit, the 33-step gain division, two 4-step multiplies, and a last state that
// loads the result into the output register. A new request is taken only back in idle.
// The input side is stalled for the whole computation and while a finished result
// cannot move into an occupied, stalled output register.
// Reset is synchronous and active low; it clears the estimate to 0, the error to 1.0
// and restores the default noise variances. Configuration writes are always taken.
module scalar_kalman_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [skf_pkg::DATA_W-1:0] i_sample_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [skf_pkg::DATA_W-1:0] o_filtered_value,
    output logic        [skf_pkg::DATA_W-1:0] o_error_level,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]        i_cfg_data
);
    import skf_pkg::*;

    // Sequencer state.
    t_state r_state;
    t_state n_state;

    // Configuration registers (unsigned Q4.28).
    logic [DATA_W-1:0]  r_process_noise;
    logic [DATA_W-1:0]  r_measure_noise;

    // Filter state: estimate in Q16.16, error variance in Q4.28.
    logic [DATA_W-1:0]  r_estimate;
    logic [DATA_W-1:0]  r_error_var;

    // Working registers of the current request.
    logic [DATA_W-1:0]  r_prior;
    logic [DATA_W:0]    r_innov;
    logic [DATA_W-1:0]  r_mag;
    logic               r_neg;
    logic [GAIN_W-1:0]  r_gain;
    logic [DATA_W-1:0]  r_corr;

    // Output register.
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_value;
    logic [DATA_W-1:0]  r_out_error;

    // Sequencer outputs.
    logic               w_in_stall;
    logic               w_load_gain;
    logic               w_load_corr;
    logic               w_update_est;
    logic               w_load_err;
    logic               w_load_out;
    t_div_req           w_div_req;
    t_mul_req           w_mul_req;

    // Unit results.
    logic               w_div_busy;
    logic               w_div_done;
    logic [GAIN_W-1:0]  w_div_quo;
    logic               w_mul_done;
    logic [PROD_W-1:0]  w_mul_prod;

    // Datapath helpers.
    logic [DATA_W:0]    w_prior_sum;
    logic [DATA_W:0]    w_innov_neg;
    logic [PROD_W:0]    w_round;
    logic [DATA_W+1:0]  w_est_ext;
    logic [DATA_W+1:0]  w_corr_ext;
    logic [DATA_W+1:0]  w_next_est;
    logic [DATA_W-1:0]  w_factor;
    logic               w_in_accept;
    logic               w_out_accept;

    assign w_in_accept  = i_in_valid && !w_in_stall;
    assign w_out_accept = r_out_valid && !i_out_stall;

    //--------------------------------------------------------------------------
    // Sequencer: next state.
    //--------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_state = S_MUL1_WAIT;
            end
            S_MUL1_WAIT: begin
                if (w_mul_done) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                n_state = S_MUL2_WAIT;
            end
            S_MUL2_WAIT: begin
                if (w_mul_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    //--------------------------------------------------------------------------
    // Sequencer: outputs. The factor (1 - gain) wraps to zero for a gain of 0;
    // that case keeps the prior as the new error and never uses the product.
    //--------------------------------------------------------------------------
    assign w_factor = ~r_gain[DATA_W-1:0] + DATA_W'(1);

    always_comb begin
        w_in_stall    = 1'b1;
        w_load_gain   = 1'b0;
        w_load_corr   = 1'b0;
        w_update_est  = 1'b0;
        w_load_err    = 1'b0;
        w_load_out    = 1'b0;
        w_div_req     = '0;
        w_mul_req     = '0;
        w_div_req.num = r_prior;
        w_div_req.den = {1'b0, r_prior} + {1'b0, r_measure_noise};
        w_mul_req.a   = r_mag;
        w_mul_req.b   = r_gain[DATA_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                w_in_stall = 1'b0;
            end
            S_PREP: begin
                w_div_req.start = 1'b1;
            end
            S_DIV: begin
                w_load_gain = w_div_done;
            end
            S_MUL1: begin
                w_mul_req.start = 1'b1;
            end
            S_MUL1_WAIT: begin
                w_load_corr = w_mul_done;
            end
            S_MUL2: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = r_prior;
                w_mul_req.b     = w_factor;
                w_update_est    = 1'b1;
            end
            S_MUL2_WAIT: begin
                w_load_err = w_mul_done;
            end
            S_DONE: begin
                w_load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
                w_in_stall = 1'b1;
            end
        endcase
    end

    //--------------------------------------------------------------------------
    // Shared units.
    //--------------------------------------------------------------------------
    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    skf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    //--------------------------------------------------------------------------
    // Configuration port. Writes to indexes outside the register list are dropped.
    //--------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise <= RESET_PROCESS_NOISE;
            r_measure_noise <= RESET_MEASURE_NOISE;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_PROCESS_NOISE) begin
                r_process_noise <= i_cfg_data;
            end
            if (i_cfg_index == REG_MEASURE_NOISE) begin
                r_measure_noise <= i_cfg_data;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Datapath.
    //--------------------------------------------------------------------------
    // The prior error saturates at the top of the Q4.28 range.
    assign w_prior_sum = {1'b0, r_error_var} + {1'b0, r_process_noise};
    assign w_innov_neg = ~r_innov + (DATA_W+1)'(1);

    // Shared rounding adder: adds one half in Q32 before the product is truncated.
    assign w_round = {1'b0, w_mul_prod} + {1'b0, HALF_Q32};

    // The estimate moves by the correction toward the sample; the sum is kept two bits
    // wider so that an overflow of the signed range can be seen and saturated.
    assign w_est_ext  = {{2{r_estimate[DATA_W-1]}}, r_estimate};
    assign w_corr_ext = {2'b00, r_corr};
    assign w_next_est = r_neg ? (w_est_ext - w_corr_ext) : (w_est_ext + w_corr_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estimate  <= '0;
            r_error_var <= ONE_Q4_28;
        end else begin
            if (w_update_est) begin
                if (w_next_est[DATA_W+1:DATA_W-1] == 3'b000
                    || w_next_est[DATA_W+1:DATA_W-1] == 3'b111) begin
                    r_estimate <= w_next_est[DATA_W-1:0];
                end else if (w_next_est[DATA_W+1]) begin
                    r_estimate <= {1'b1, {(DATA_W-1){1'b0}}};
                end else begin
                    r_estimate <= {1'b0, {(DATA_W-1){1'b1}}};
                end
            end
            if (w_load_err) begin
                // A zero gain leaves the whole prior as the new error.
                r_error_var <= (r_gain == '0) ? r_prior : w_round[PROD_W-1:DATA_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_prior <= w_prior_sum[DATA_W] ? {DATA_W{1'b1}} : w_prior_sum[DATA_W-1:0];
            r_innov <= {i_sample_value[DATA_W-1], i_sample_value}
                       - {r_estimate[DATA_W-1], r_estimate};
        end
        if (r_state == S_PREP) begin
            r_neg <= r_innov[DATA_W];
            r_mag <= r_innov[DATA_W] ? w_innov_neg[DATA_W-1:0] : r_innov[DATA_W-1:0];
        end
        if (w_load_gain) begin
            r_gain <= w_div_quo;
        end
        if (w_load_corr) begin
            // A gain of exactly one passes the whole innovation through.
            r_corr <= r_gain[DATA_W] ? r_mag : w_round[PROD_W-1:DATA_W];
        end
    end

    //--------------------------------------------------------------------------
    // Output register. A new result may enter in the cycle the old one is taken.
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_value <= r_estimate;
            r_out_error <= r_error_var;
        end
    end

    assign o_in_stall       = w_in_stall;
    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_error_level    = r_out_error;

`ifndef SYNTH
    // The gain never exceeds one, since the prior never exceeds the denominator.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (w_div_quo <= ONE_Q32))
        else $error("gain above one");

    // The updated error never grows beyond the prior it was computed from.
    a_error_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_err |=> (r_error_var <= $past(r_prior)))
        else $error("error above prior");

    // Once a request is taken, the input side stalls until its result is loaded.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input not stalled during computation");

    // The divider is only busy while the sequencer waits for the gain.
    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DIV))
        else $error("divider busy outside its step");
`endif

endmodule
